/* design/apd_pkg.sv */
// ---------------------------------------------------------------------------
// apd_pkg: shared types and constants for the Art-Net packet decoder
// Positions of the header fields, opcodes, status codes and result layout.
// ---------------------------------------------------------------------------
`default_nettype none

package apd_pkg;

    localparam int MaxChannelsDef = 512;

    // queue of finished results between the parser and the output port
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [9:0] PosNameEnd = 10'd8;
    localparam logic [9:0] PosOpLo    = 10'd8;
    localparam logic [9:0] PosOpHi    = 10'd9;
    localparam logic [9:0] PosVerHi   = 10'd10;
    localparam logic [9:0] PosVerLo   = 10'd11;
    localparam logic [9:0] PosSeq     = 10'd12;
    localparam logic [9:0] PosPhys    = 10'd13;
    localparam logic [9:0] PosSubUni  = 10'd14;
    localparam logic [9:0] PosNet     = 10'd15;
    localparam logic [9:0] PosCntHi   = 10'd16;
    localparam logic [9:0] PosCntLo   = 10'd17;
    localparam logic [9:0] PosData    = 10'd18;
    localparam logic [9:0] PosMax     = 10'd1023;

    localparam logic [10:0] MinLen     = 11'd10;
    localparam logic [10:0] DmxHdrLen  = 11'd18;
    localparam logic [10:0] PollLen    = 11'd14;

    localparam logic [15:0] OpDmx       = 16'h5000;
    localparam logic [15:0] OpPoll      = 16'h2000;
    localparam logic [15:0] OpPollReply = 16'h2100;
    localparam logic [7:0]  NetMask     = 8'h7F;
    localparam logic [15:0] MinVersionRst = 16'd14;

    localparam logic KindLevel   = 1'b0;
    localparam logic KindSummary = 1'b1;

    typedef enum logic [2:0] {
        StDmx    = 3'd0,
        StPoll   = 3'd1,
        StReply  = 3'd2,
        StOther  = 3'd3,
        StReject = 3'd4
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [8:0]  channel_index;
        logic [7:0]  level;
        logic [2:0]  status;
        logic [14:0] universe;
        logic [7:0]  sequence_res;
        logic [7:0]  physical_port;
        logic [15:0] opcode;
        logic [9:0]  channel_count;
        logic        run_last;
    } t_result;

    // results produced by one byte: level first, then summary
    typedef struct packed {
        logic    lvl_vld;
        logic    sum_vld;
        t_result lvl;
        t_result sum;
    } t_push;

    function automatic logic [7:0] name_byte(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h41; // A
            3'd1: c = 8'h72; // r
            3'd2: c = 8'h74; // t
            3'd3: c = 8'h2D; // -
            3'd4: c = 8'h4E; // N
            3'd5: c = 8'h65; // e
            3'd6: c = 8'h74; // t
            3'd7: c = 8'h00;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/apd_parse.sv */
// ---------------------------------------------------------------------------
// apd_parse: byte parser of the Art-Net decoder
// Tracks byte position, captures header fields and forms level results for
// accepted data bytes and a summary result for each packet's last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module apd_parse #(
    parameter int MAX_CHANNELS = apd_pkg::MaxChannelsDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [15:0]   i_cfg_wr_data,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end_of_packet,
    output apd_pkg::t_push     o_push
);
    import apd_pkg::*;

    localparam logic [15:0] MaxCh = 16'(MAX_CHANNELS);

    logic [15:0] r_min_version;
    logic [9:0]  r_pos, n_pos;
    logic        r_name, n_name;
    logic [15:0] r_opcode, n_opcode;
    logic [15:0] r_version, n_version;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_phys, n_phys;
    logic [7:0]  r_subuni, n_subuni;
    logic [6:0]  r_net, n_net;
    logic [15:0] r_count, n_count;
    logic        r_hdr_rej, n_hdr_rej;

    logic [9:0]  lvl_idx;
    logic [10:0] len;
    logic        count_ok;
    t_status     status;
    t_push       push;

    always_comb begin
        n_pos     = r_pos;
        n_name    = r_name;
        n_opcode  = r_opcode;
        n_version = r_version;
        n_seq     = r_seq;
        n_phys    = r_phys;
        n_subuni  = r_subuni;
        n_net     = r_net;
        n_count   = r_count;
        n_hdr_rej = r_hdr_rej;
        push      = '0;
        lvl_idx   = r_pos - PosData;
        len       = {1'b0, r_pos} + 11'd1;
        count_ok  = 1'b0;
        status    = StReject;

        if (r_pos < PosNameEnd) begin
            if (i_data_byte != name_byte(r_pos[2:0])) begin
                n_name = 1'b0;
            end
        end else begin
            unique case (r_pos)
                PosOpLo:   n_opcode  = {r_opcode[15:8], i_data_byte};
                PosOpHi:   n_opcode  = {i_data_byte, r_opcode[7:0]};
                PosVerHi:  n_version = {i_data_byte, r_version[7:0]};
                PosVerLo:  n_version = {r_version[15:8], i_data_byte};
                PosSeq:    n_seq     = i_data_byte;
                PosPhys:   n_phys    = i_data_byte;
                PosSubUni: n_subuni  = i_data_byte;
                PosNet:    n_net     = i_data_byte[6:0] & NetMask[6:0];
                PosCntHi:  n_count   = {i_data_byte, r_count[7:0]};
                PosCntLo: begin
                    n_count   = {r_count[15:8], i_data_byte};
                    count_ok  = (n_count >= 16'd2) && (n_count <= MaxCh) && !n_count[0];
                    n_hdr_rej = !(r_name && (r_opcode == OpDmx) &&
                                  (r_version >= r_min_version) && count_ok);
                end
                default: begin
                    // data area: emit a level while inside the declared count of an accepted header
                    if (!r_hdr_rej && ({6'd0, lvl_idx} < r_count)) begin
                        push.lvl_vld = 1'b1;
                    end
                end
            endcase
        end

        // summary classification sees this byte's field updates
        if ((len >= MinLen) && n_name) begin
            if (n_opcode == OpDmx) begin
                if ((len >= DmxHdrLen) && !n_hdr_rej &&
                    (n_count <= {5'd0, len - DmxHdrLen})) begin
                    status = StDmx;
                end
            end else if (n_opcode == OpPoll) begin
                if ((len >= PollLen) && (n_version >= r_min_version)) begin
                    status = StPoll;
                end
            end else if (n_opcode == OpPollReply) begin
                status = StReply;
            end else begin
                status = StOther;
            end
        end

        push.lvl.kind          = KindLevel;
        push.lvl.channel_index = lvl_idx[8:0];
        push.lvl.level         = i_data_byte;
        push.lvl.run_last      = !i_end_of_packet;

        push.sum_vld      = i_end_of_packet;
        push.sum.kind     = KindSummary;
        push.sum.status   = status;
        push.sum.run_last = 1'b1;
        if (status != StReject) begin
            push.sum.opcode = n_opcode;
        end
        if (status == StDmx) begin
            push.sum.universe      = {n_net, n_subuni};
            push.sum.sequence_res  = n_seq;
            push.sum.physical_port = n_phys;
            push.sum.channel_count = n_count[9:0];
        end

        if (i_end_of_packet) begin
            // end of datagram: return to the idle packet state
            n_pos     = '0;
            n_name    = 1'b1;
            n_opcode  = '0;
            n_version = '0;
            n_seq     = '0;
            n_phys    = '0;
            n_subuni  = '0;
            n_net     = '0;
            n_count   = '0;
            n_hdr_rej = 1'b0;
        end else if (r_pos != PosMax) begin
            n_pos = r_pos + 10'd1;
        end

        if (!i_accept) begin
            push.lvl_vld = 1'b0;
            push.sum_vld = 1'b0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_version <= MinVersionRst;
        end else if (i_cfg_wr_en) begin
            r_min_version <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_name    <= 1'b1;
            r_opcode  <= '0;
            r_version <= '0;
            r_seq     <= '0;
            r_phys    <= '0;
            r_subuni  <= '0;
            r_net     <= '0;
            r_count   <= '0;
            r_hdr_rej <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_name    <= n_name;
            r_opcode  <= n_opcode;
            r_version <= n_version;
            r_seq     <= n_seq;
            r_phys    <= n_phys;
            r_subuni  <= n_subuni;
            r_net     <= n_net;
            r_count   <= n_count;
            r_hdr_rej <= n_hdr_rej;
        end
    end

endmodule

`default_nettype wire

/* design/apd_queue.sv */
// ---------------------------------------------------------------------------
// apd_queue: result queue of the Art-Net decoder
// Takes up to two results per cycle and hands out one per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module apd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire apd_pkg::t_push i_push,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output apd_pkg::t_result   o_result
);
    import apd_pkg::*;

    t_result                r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QueuePtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QueueCntW-1:0]   r_count, n_count;
    logic [QueueCntW-1:0]   push_cnt;
    logic                   pop;
    t_result                first;

    assign o_valid  = (r_count != '0);
    // hold off input unless two entries are free
    assign o_full   = (r_count > QueueCntW'(QueueDepth - 2));
    assign pop      = o_valid && !i_stall;
    assign push_cnt = QueueCntW'(i_push.lvl_vld) + QueueCntW'(i_push.sum_vld);
    assign first    = i_push.lvl_vld ? i_push.lvl : i_push.sum;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QueuePtrW'(push_cnt);
        n_rd_ptr = r_rd_ptr + QueuePtrW'(pop);
        n_count  = r_count + push_cnt - QueueCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != '0) begin
            r_mem[r_wr_ptr] <= first;
        end
        if (i_push.lvl_vld && i_push.sum_vld) begin
            r_mem[r_wr_ptr + QueuePtrW'(1)] <= i_push.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* design/artnet_packet_decoder_top.sv */
// ---------------------------------------------------------------------------
// artnet_packet_decoder_top: Art-Net DMX packet decoder
// Parses a UDP payload byte stream, emits channel levels and a packet summary.
//
//   channel   direction  handshake                payload
//   input     in         i_in_valid / o_in_stall  data_byte, end_of_packet
//   output    out        o_out_valid / i_out_stall result fields
//   config    in         i_cfg_wr_en              min_version
//
// One byte is taken per cycle while the input is not stalled; its results
// are registered in the output queue, from which they are handed out.
// A final data byte can yield two results, its level and the summary.
// Input stalls when fewer than two queue entries are free.
// Synchronous reset returns the parser to byte position zero, empties the
// queue and sets min_version to 14.
// ---------------------------------------------------------------------------
`default_nettype none

module artnet_packet_decoder_top #(
    parameter int MAX_CHANNELS = apd_pkg::MaxChannelsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_packet,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [8:0]       o_channel_index,
    output logic [7:0]       o_level,
    output logic [2:0]       o_packet_status,
    output logic [14:0]      o_universe,
    output logic [7:0]       o_sequence_res,
    output logic [7:0]       o_physical_port,
    output logic [15:0]      o_opcode,
    output logic [9:0]       o_channel_count,
    output logic             o_run_last
);
    import apd_pkg::*;

    t_push   push;
    t_result res;
    logic    full;
    logic    accept;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    apd_parse #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_push          (push)
    );

    apd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (res)
    );

    assign o_result_kind   = res.kind;
    assign o_channel_index = res.channel_index;
    assign o_level         = res.level;
    assign o_packet_status = res.status;
    assign o_universe      = res.universe;
    assign o_sequence_res  = res.sequence_res;
    assign o_physical_port = res.physical_port;
    assign o_opcode        = res.opcode;
    assign o_channel_count = res.channel_count;
    assign o_run_last      = res.run_last;

endmodule

`default_nettype wire
